FILE: rtl/fsts_pkg.sv
package fsts_pkg;

  localparam int unsigned MaxTasks     = 16;
  localparam int unsigned ArrivalDepth = 16;
  localparam int unsigned SlotW        = $clog2(MaxTasks);
  localparam int unsigned ArrW         = $clog2(ArrivalDepth);
  localparam int unsigned SlotCntW     = $clog2(MaxTasks + 1);
  localparam int unsigned ArrCntW      = $clog2(ArrivalDepth + 1);

  localparam logic FuncAdd  = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StDrainRd,
    StDrainChk,
    StSortMove,
    StInsert,
    StScanRd,
    StScanCmp,
    StPickRd,
    StPickWr,
    StReport
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] vrt;
    logic [31:0] order;
    logic [31:0] rt;
    logic [31:0] len;
  } slot_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] start;
    logic [31:0] len;
  } arr_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] len;
  } pend_t;

endpackage

FILE: rtl/fair_share_task_scheduler_core.sv
// Channel   Direction  Signals
// in        input      in_valid_i, in_ready_o, func_i, task_id_i, start_time_i, duration_i
// out       output     out_valid_o, out_ready_i, tick_number_o .. overflow_o
//
// An add appends one arrival, or sets overflow when the arrival memory is full. A tick drains
// the arrivals whose start equals the tick count, insertion-sorts them by id, writes each into
// a free slot, scans the slot memory for the minimum, picks and reports.
// The slot memory and arrival memory each have one registered read port.
// Reset clears control state; memory contents stay undefined and are guarded by valid
// bits (slots) or the fill count (arrivals). A result waits in the output register and blocks the next item.
module fair_share_task_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] start_time_i,
  input  logic [31:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] tick_number_o,
  output logic [4:0]  queued_count_o,
  output logic [7:0]  running_id_o,
  output logic        idle_o,
  output logic        completed_o,
  output logic        all_empty_o,
  output logic        overflow_o
);
  import fsts_pkg::*;

  arr_t  arr_mem [ArrivalDepth];
  slot_t slot_mem [MaxTasks];
  arr_t  arr_rd;
  slot_t slot_rd;

  state_e state_q, state_d;
  logic [ArrW-1:0]    head_q, head_d;
  logic [ArrCntW-1:0] fill_q, fill_d;
  logic [MaxTasks-1:0] valid_q, valid_d;
  logic        cur_v_q, cur_v_d;
  slot_t       cur_q, cur_d;
  logic [31:0] min_vrt_q, min_vrt_d, tick_q, tick_d, order_q, order_d;
  logic        ovf_q, ovf_d;

  pend_t pend_q [ArrivalDepth];
  pend_t pend_d [ArrivalDepth];
  logic [ArrCntW-1:0] n_q, n_d, j_q, j_d, ins_q, ins_d;
  pend_t new_q, new_d;

  logic [SlotW-1:0] scan_q, scan_d, best_q, best_d;
  logic             have_q, have_d, last_q, last_d;
  slot_t            bslot_q, bslot_d;

  logic        ov_q, ov_d;
  logic [31:0] o_tick_q, o_tick_d;
  logic [4:0]  o_cnt_q, o_cnt_d;
  logic [7:0]  o_id_q, o_id_d;
  logic        o_idle_q, o_idle_d, o_done_q, o_done_d, o_emp_q, o_emp_d;

  logic             arr_we, slot_we;
  logic [ArrW-1:0]  arr_wa, arr_ra;
  arr_t             arr_wd;
  logic [SlotW-1:0] slot_wa, slot_ra;
  slot_t            slot_wd;

  always_ff @(posedge clk_i) begin
    if (arr_we) arr_mem[arr_wa] <= arr_wd;
    arr_rd <= arr_mem[arr_ra];
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  logic [SlotW-1:0] free_idx;
  logic             free_ok;
  logic [SlotCntW-1:0] vcount;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SlotW'(i);
        free_ok  = 1'b1;
      end
    end
    vcount = '0;
    for (int i = 0; i < MaxTasks; i++) vcount = vcount + SlotCntW'(valid_q[i]);
  end

  logic [31:0] nrt;
  assign nrt = cur_q.rt + 32'd1;

  always_comb begin
    state_d = state_q;
    head_d = head_q; fill_d = fill_q; valid_d = valid_q;
    cur_v_d = cur_v_q; cur_d = cur_q; min_vrt_d = min_vrt_q;
    tick_d = tick_q; order_d = order_q; ovf_d = ovf_q;
    pend_d = pend_q; n_d = n_q; j_d = j_q; ins_d = ins_q;
    new_d = new_q;
    scan_d = scan_q; best_d = best_q; have_d = have_q; last_d = last_q;
    bslot_d = bslot_q;
    ov_d = ov_q; o_tick_d = o_tick_q; o_cnt_d = o_cnt_q; o_id_d = o_id_q;
    o_idle_d = o_idle_q; o_done_d = o_done_q; o_emp_d = o_emp_q;
    arr_we = 1'b0; arr_wa = head_q + ArrW'(fill_q); arr_ra = head_q;
    arr_wd = '{id: task_id_i, start: start_time_i, len: duration_i};
    slot_we = 1'b0; slot_wa = free_idx; slot_ra = scan_q; slot_wd = '0;
    in_ready_o = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          if (func_i == FuncAdd) begin
            if (fill_q >= ArrCntW'(ArrivalDepth)) ovf_d = 1'b1;
            else begin
              arr_we = 1'b1;
              fill_d = fill_q + 1'b1;
            end
          end else begin
            n_d = '0;
            state_d = StDrainRd;
          end
        end
      end
      StDrainRd: begin
        if (fill_q == '0) begin
          ins_d = '0;
          state_d = StInsert;
        end else state_d = StDrainChk;
      end
      StDrainChk: begin
        if (arr_rd.start == tick_q) begin
          head_d = head_q + 1'b1;
          fill_d = fill_q - 1'b1;
          new_d = '{id: arr_rd.id, len: arr_rd.len};
          j_d = n_q;
          state_d = StSortMove;
        end else begin
          ins_d = '0;
          state_d = StInsert;
        end
      end
      StSortMove: begin
        if (j_q != '0 && pend_q[ArrW'(j_q - 1'b1)].id > new_q.id) begin
          pend_d[ArrW'(j_q)] = pend_q[ArrW'(j_q - 1'b1)];
          j_d = j_q - 1'b1;
        end else begin
          pend_d[ArrW'(j_q)] = new_q;
          n_d = n_q + 1'b1;
          if (n_q + 1'b1 >= ArrCntW'(ArrivalDepth)) begin
            ins_d = '0;
            state_d = StInsert;
          end else state_d = StDrainRd;
        end
      end
      StInsert: begin
        if (ins_q == n_q) begin
          scan_d = '0;
          have_d = 1'b0;
          last_d = 1'b0;
          state_d = StScanRd;
        end else begin
          if (!free_ok) ovf_d = 1'b1;
          else begin
            slot_we = 1'b1;
            slot_wd = '{id: pend_q[ArrW'(ins_q)].id, vrt: min_vrt_q, order: order_q,
                        rt: 32'd0, len: pend_q[ArrW'(ins_q)].len};
            valid_d[free_idx] = 1'b1;
            order_d = order_q + 32'd1;
          end
          ins_d = ins_q + 1'b1;
        end
      end
      StScanRd: begin
        last_d = (scan_q == SlotW'(MaxTasks - 1));
        state_d = StScanCmp;
      end
      StScanCmp: begin
        if (valid_q[scan_q] && (!have_q || slot_rd.vrt < bslot_q.vrt ||
            (slot_rd.vrt == bslot_q.vrt && slot_rd.order < bslot_q.order))) begin
          have_d = 1'b1;
          best_d = scan_q;
          bslot_d = slot_rd;
        end
        if (last_q) state_d = StPickWr;
        else begin
          scan_d = scan_q + 1'b1;
          state_d = StScanRd;
        end
      end
      StPickWr: begin
        if (have_q && (!cur_v_q || bslot_q.vrt < cur_q.vrt)) begin
          valid_d[best_q] = cur_v_q;
          if (cur_v_q) begin
            slot_we = 1'b1;
            slot_wa = best_q;
            slot_wd = '{id: cur_q.id, vrt: cur_q.vrt, order: order_q,
                        rt: cur_q.rt, len: cur_q.len};
            order_d = order_q + 32'd1;
          end
          cur_v_d = 1'b1;
          cur_d = bslot_q;
          min_vrt_d = bslot_q.vrt;
        end
        state_d = StReport;
      end
      StReport: begin
        o_tick_d = tick_q;
        tick_d = tick_q + 32'd1;
        o_done_d = 1'b0;
        if (cur_v_q) begin
          cur_d.rt = nrt;
          cur_d.vrt = cur_q.vrt + 32'd1;
          o_cnt_d = 5'(vcount + 1'b1);
          o_id_d = cur_q.id;
          o_idle_d = 1'b0;
          if (nrt >= cur_q.len) begin
            o_done_d = 1'b1;
            cur_v_d = 1'b0;
          end
        end else begin
          o_cnt_d = '0;
          o_id_d = '0;
          o_idle_d = 1'b1;
        end
        o_emp_d = (fill_q == '0) && (vcount == '0) && !(cur_v_q && !(nrt >= cur_q.len));
        ov_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q <= '0; fill_q <= '0; valid_q <= '0;
      cur_v_q <= 1'b0; cur_q <= '0;
      min_vrt_q <= '0; tick_q <= '0; order_q <= '0; ovf_q <= 1'b0;
      ov_q <= 1'b0;
      n_q <= '0; j_q <= '0; ins_q <= '0;
      scan_q <= '0; best_q <= '0; have_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d; fill_q <= fill_d; valid_q <= valid_d;
      cur_v_q <= cur_v_d; cur_q <= cur_d;
      min_vrt_q <= min_vrt_d; tick_q <= tick_d; order_q <= order_d; ovf_q <= ovf_d;
      ov_q <= ov_d;
      n_q <= n_d; j_q <= j_d; ins_q <= ins_d;
      scan_q <= scan_d; best_q <= best_d; have_q <= have_d; last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    new_q <= new_d;
    bslot_q <= bslot_d;
    o_tick_q <= o_tick_d; o_cnt_q <= o_cnt_d; o_id_q <= o_id_d;
    o_idle_q <= o_idle_d; o_done_q <= o_done_d; o_emp_q <= o_emp_d;
  end

  assign out_valid_o    = ov_q;
  assign tick_number_o  = o_tick_q;
  assign queued_count_o = o_cnt_q;
  assign running_id_o   = o_id_q;
  assign idle_o         = o_idle_q;
  assign completed_o    = o_done_q;
  assign all_empty_o    = o_emp_q;
  assign overflow_o     = ovf_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ArrCntW'(ArrivalDepth))
    else $error("arrival fill exceeds depth");
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle) && !ov_q)
    else $error("input accepted while busy");
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_idle_q) |-> (o_cnt_q == '0) && !o_done_q)
    else $error("idle result carries a task");
  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StReport) |=> tick_q == $past(tick_q) + 32'd1)
    else $error("tick counter did not advance");

endmodule

FILE: sim/tb.sv
module tb;
  import fsts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [7:0]  task_id_i;
  logic [31:0] start_time_i;
  logic [31:0] duration_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] tick_number_o;
  logic [4:0]  queued_count_o;
  logic [7:0]  running_id_o;
  logic        idle_o;
  logic        completed_o;
  logic        all_empty_o;
  logic        overflow_o;

  localparam int   StallLimit = 20000;

  typedef struct packed {
    logic [31:0] tick;
    logic [4:0]  count;
    logic [7:0]  id;
    logic        idle;
    logic        done;
    logic        empty;
    logic        ovf;
  } report_t;

  fair_share_task_scheduler_core u_top (.*);

  // Scheduler shadow state.
  logic [7:0]  fifo_id [ArrivalDepth];
  logic [31:0] fifo_start [ArrivalDepth];
  logic [31:0] fifo_len [ArrivalDepth];
  int          fifo_head;
  int          fifo_fill;
  logic        tbl_vld [MaxTasks];
  logic [7:0]  tbl_id [MaxTasks];
  logic [31:0] tbl_vrt [MaxTasks];
  logic [31:0] tbl_ord [MaxTasks];
  logic [31:0] tbl_rt [MaxTasks];
  logic [31:0] tbl_len [MaxTasks];
  logic        run_vld;
  logic [7:0]  run_id;
  logic [31:0] run_vrt;
  logic [31:0] run_rt;
  logic [31:0] run_len;
  logic [31:0] floor_vrt;
  logic [31:0] tick_cnt;
  logic [31:0] ord_cnt;
  logic        ovf_flag;

  report_t     pending_reports[$];
  int          mismatches;
  int          reports_seen;
  int          ticks_sent;
  int          adds_sent;
  int          idle_cycles;
  bit          in_noidle;
  bit          out_noidle;

  task automatic table_put(int s, logic [7:0] id, logic [31:0] vrt, logic [31:0] rt,
                           logic [31:0] len);
    tbl_vld[s] = 1'b1;
    tbl_id[s]  = id;
    tbl_vrt[s] = vrt;
    tbl_rt[s]  = rt;
    tbl_len[s] = len;
    tbl_ord[s] = ord_cnt;
    ord_cnt    = ord_cnt + 1;
  endtask

  task automatic schedule_item(logic f, logic [7:0] id, logic [31:0] st, logic [31:0] du);
    logic [7:0]  did [ArrivalDepth];
    logic [31:0] dlen [ArrivalDepth];
    int          n;
    int          j;
    int          s;
    int          best;
    int          cnt;
    logic [7:0]  bid;
    logic [31:0] bvrt;
    logic [31:0] brt;
    logic [31:0] blen;
    report_t     r;
    n = 0;
    best = -1;
    cnt = 0;
    if (f == FuncAdd) begin
      if (fifo_fill >= ArrivalDepth) begin
        ovf_flag = 1'b1;
      end else begin
        s = (fifo_head + fifo_fill) % ArrivalDepth;
        fifo_id[s] = id;
        fifo_start[s] = st;
        fifo_len[s] = du;
        fifo_fill++;
      end
      return;
    end
    while (fifo_fill > 0 && fifo_start[fifo_head] == tick_cnt) begin
      j = n;
      while (j > 0 && did[j-1] > fifo_id[fifo_head]) begin
        did[j] = did[j-1];
        dlen[j] = dlen[j-1];
        j--;
      end
      did[j] = fifo_id[fifo_head];
      dlen[j] = fifo_len[fifo_head];
      n++;
      fifo_head = (fifo_head + 1) % ArrivalDepth;
      fifo_fill--;
    end
    for (int i = 0; i < n; i++) begin
      s = -1;
      for (int k = MaxTasks - 1; k >= 0; k--) if (!tbl_vld[k]) s = k;
      if (s < 0) ovf_flag = 1'b1;
      else table_put(s, did[i], floor_vrt, 32'd0, dlen[i]);
    end
    for (int i = 0; i < MaxTasks; i++) begin
      if (tbl_vld[i] && (best < 0 || tbl_vrt[i] < tbl_vrt[best] ||
          (tbl_vrt[i] == tbl_vrt[best] && tbl_ord[i] < tbl_ord[best])))
        best = i;
    end
    if (best >= 0 && (!run_vld || tbl_vrt[best] < run_vrt)) begin
      bid = tbl_id[best];
      bvrt = tbl_vrt[best];
      brt = tbl_rt[best];
      blen = tbl_len[best];
      tbl_vld[best] = 1'b0;
      if (run_vld) table_put(best, run_id, run_vrt, run_rt, run_len);
      run_vld = 1'b1;
      run_id = bid;
      run_vrt = bvrt;
      run_rt = brt;
      run_len = blen;
      floor_vrt = bvrt;
    end
    for (int i = 0; i < MaxTasks; i++) if (tbl_vld[i]) cnt++;
    r = '0;
    r.tick = tick_cnt;
    if (run_vld) begin
      run_rt = run_rt + 1;
      run_vrt = run_vrt + 1;
      r.count = 5'(cnt + 1);
      r.id = run_id;
      r.done = run_rt >= run_len;
      if (r.done) run_vld = 1'b0;
    end else begin
      r.idle = 1'b1;
    end
    r.empty = fifo_fill == 0 && cnt == 0 && !run_vld;
    r.ovf = ovf_flag;
    tick_cnt = tick_cnt + 1;
    pending_reports.insert(pending_reports.size(), r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_item(logic f, logic [7:0] id, logic [31:0] st, logic [31:0] du);
    while (!in_noidle && $urandom_range(99) < 25) begin
      in_valid_i   <= 1'b0;
      func_i       <= 1'($urandom_range(1));
      task_id_i    <= 8'($urandom);
      start_time_i <= $urandom;
      duration_i   <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    task_id_i    <= id;
    start_time_i <= st;
    duration_i   <= du;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    schedule_item(f, id, st, du);
    if (f == FuncTick) ticks_sent++;
    else adds_sent++;
  endtask

  task automatic add_task(logic [7:0] id, logic [31:0] st, logic [31:0] du);
    send_item(FuncAdd, id, st, du);
  endtask

  task automatic tick_once();
    send_item(FuncTick, 8'($urandom), $urandom, $urandom);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= out_noidle || ($urandom_range(99) >= 25);
  end

  always @(posedge clk_i) begin
    report_t exp_r;
    report_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {tick_number_o, queued_count_o, running_id_o, idle_o, completed_o,
             all_empty_o, overflow_o};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", got);
      end else begin
        exp_r = pending_reports.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("report mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Extremes: id 0/255, zero and huge durations, stale head, same-tick id sort.
  task automatic test_directed();
    add_task(8'd255, 32'd0, 32'd0);
    add_task(8'd0, 32'd0, 32'd2);
    add_task(8'd7, 32'd0, 32'd1);
    add_task(8'd7, 32'd0, 32'hFFFF_FFFF);
    tick_once();
    tick_once();
    add_task(8'hAA, 32'hFFFF_FFFF, 32'd3);
    add_task(8'h55, tick_cnt + 1, 32'd1);
    tick_once();
    tick_once();
    tick_once();
    tick_once();
  endtask

  // Flood the FIFO and then the table to hit both drop paths.
  task automatic test_overflow();
    logic [31:0] t;
    t = tick_cnt;
    for (int i = 0; i < 17; i++) add_task(8'(17 - i), t, 32'(i % 3));
    tick_once();
    t = tick_cnt;
    for (int i = 0; i < 16; i++) add_task(8'($urandom), t, 32'd5);
    tick_once();
    for (int i = 0; i < 20; i++) tick_once();
  endtask

  task automatic test_random(int total);
    logic [31:0] st;
    int          sent;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(9))
          0:       st = $urandom;
          1:       st = tick_cnt - 1;
          default: st = tick_cnt + $urandom_range(3);
        endcase
        add_task(8'($urandom), st,
                 ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(6)));
      end else begin
        tick_once();
      end
      sent++;
      if (sent == total / 2) in_noidle = 1'b1;
      if (sent == total / 2 + 100) in_noidle = 1'b0;
    end
    // A stale head eventually blocks; flush with a small final burst of ticks.
    for (int i = 0; i < 40; i++) tick_once();
  endtask

  initial begin
    for (int i = 0; i < MaxTasks; i++) tbl_vld[i] = 1'b0;
    fifo_head = 0;
    fifo_fill = 0;
    run_vld = 1'b0;
    run_id = '0;
    run_vrt = '0;
    run_rt = '0;
    run_len = '0;
    floor_vrt = '0;
    tick_cnt = '0;
    ord_cnt = '0;
    ovf_flag = 1'b0;
    mismatches = 0;
    reports_seen = 0;
    ticks_sent = 0;
    adds_sent = 0;
    in_noidle = 1'b0;
    out_noidle = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    func_i = FuncAdd;
    task_id_i = '0;
    start_time_i = '0;
    duration_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    out_noidle = 1'b1;
    test_random(300);
    out_noidle = 1'b0;
    test_random(350);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d adds and %0d ticks, %0d reports checked.",
             adds_sent, ticks_sent, reports_seen);
    $display("Overflow drops, stale heads and same-tick sorting were exercised.");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
